@@ rtl/sbsm_pkg.sv @@
// Shared types and constants for the serial bank switch mapper.
`default_nettype none

package sbsm_pkg;

    // Result target codes
    typedef enum logic [2:0] {
        TGT_NONE = 3'd0,
        TGT_CHR  = 3'd1,
        TGT_NT   = 3'd2,
        TGT_RAM  = 3'd3,
        TGT_ROM  = 3'd4,
        TGT_REG  = 3'd5
    } t_target;

    // Configuration register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_CHR_COUNT   = 2'd0,
        REG_PRG_COUNT   = 2'd1,
        REG_RAM_PRESENT = 2'd2
    } t_reg_idx;

    // Mapper register picked by address bits 14..13
    typedef enum logic [1:0] {
        SEL_CONTROL = 2'd0,
        SEL_CHR0    = 2'd1,
        SEL_CHR1    = 2'd2,
        SEL_PRG     = 2'd3
    } t_map_sel;

    // Address regions, address bits 15..13 (4..7 are PRG ROM space)
    localparam logic [2:0] RGN_CHR = 3'd0;
    localparam logic [2:0] RGN_NT  = 3'd1;
    localparam logic [2:0] RGN_IO  = 3'd2;
    localparam logic [2:0] RGN_RAM = 3'd3;

    localparam int          CfgAddrW   = 4;
    localparam int          CfgDataW   = 32;
    localparam logic [5:0]  ShiftEmpty = 6'h20;
    localparam logic [5:0]  ChrCountRst = 6'd2;
    localparam logic [5:0]  PrgCountRst = 6'd2;
    localparam logic [4:0]  ChrHighRst  = 5'd1;

    // Remainder unit: one dividend bit per cycle
    localparam int          ModSteps = 5;
    localparam int          StepW    = $clog2(ModSteps);
    localparam logic [StepW-1:0] StepFirst = StepW'(ModSteps - 1);
    localparam logic [StepW-1:0] StepLast  = '0;

    typedef enum logic {
        ST_RUN = 1'b0,
        ST_MOD = 1'b1
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic latch;       // take input transfer into the item register
        logic exec;        // translate held item, update mapper, load result
        logic mod_step;    // advance remainder unit
        logic bank_write;  // write remainder into the selected bank register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic needs_mod;   // held item completes a bank register load
    } t_stat;

endpackage

`default_nettype wire

@@ rtl/sbsm_ifs.sv @@
// Valid/ready channel interfaces for bus accesses and translated results.
`default_nettype none

interface sbsm_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source (output valid, command, address, write_data, input ready);
    modport sink   (input valid, command, address, write_data, output ready);
endinterface

interface sbsm_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  target;
    logic [18:0] offset;
    logic [1:0]  nametable_slot;
    logic [1:0]  mirroring;

    modport source (output valid, target, offset, nametable_slot, mirroring, input ready);
    modport sink   (input valid, target, offset, nametable_slot, mirroring, output ready);
endinterface

`default_nettype wire

@@ rtl/sbsm_ctrl.sv @@
// Controller: item/result handshake and sequencing of bank remainder steps.
`default_nettype none

module sbsm_ctrl import sbsm_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state           r_state, n_state;
    logic             r_pend, n_pend;
    logic             r_out_valid, n_out_valid;
    logic [StepW-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_step      <= StepFirst;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
        end
    end

    always_comb begin
        logic out_free;
        out_free    = !r_out_valid || i_out_ready;
        n_state     = r_state;
        n_step      = r_step;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            ST_RUN: begin
                o_cmd.exec = r_pend && out_free;
                o_in_ready = !r_pend || (o_cmd.exec && !i_stat.needs_mod);
                if (o_cmd.exec && i_stat.needs_mod) begin
                    n_state = ST_MOD;
                    n_step  = StepFirst;
                end
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                n_step         = r_step - 1'b1;
                if (r_step == StepLast) begin
                    o_cmd.bank_write = 1'b1;
                    n_state          = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
        o_cmd.latch = i_in_valid && o_in_ready;
        n_pend      = o_cmd.latch ? 1'b1 : (o_cmd.exec ? 1'b0 : r_pend);
        n_out_valid = o_cmd.exec ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ rtl/sbsm_dp.sv @@
// Datapath: config registers, mapper state, address translation, remainder unit.
`default_nettype none

module sbsm_dp import sbsm_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_stat                    o_stat,
    input  wire logic                i_in_command,
    input  wire logic [15:0]         i_in_address,
    input  wire logic [7:0]          i_in_write_data,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_idx,
    input  wire logic [CfgDataW-1:0] i_cfg_wdata,
    output logic [CfgDataW-1:0]      o_cfg_rdata,
    output t_target                  o_target,
    output logic [18:0]              o_offset,
    output logic [1:0]               o_slot,
    output logic [1:0]               o_mirroring
);

    // held item
    logic        r_cmd;
    logic [15:0] r_addr;
    logic [7:0]  r_wdata;

    // configuration
    logic [5:0]  r_chr_cnt;
    logic [5:0]  r_prg_cnt;
    logic        r_ram;

    // mapper state
    logic [5:0]  r_shift, n_shift;
    logic [4:0]  r_control, n_control;
    logic [4:0]  r_chr_low, n_chr_low;
    logic [4:0]  r_chr_high, n_chr_high;
    logic [4:0]  r_prg_low, n_prg_low;

    // remainder unit
    logic [5:0]  r_div_rem;
    logic [4:0]  r_div_num;
    logic [5:0]  r_div_den;
    t_map_sel    r_div_sel;

    // result register
    t_target     r_target, n_target;
    logic [18:0] r_offset, n_offset;
    logic [1:0]  r_slot, n_slot;

    logic [6:0]  div_trial;
    logic [5:0]  div_rem_nx;
    logic [4:0]  bank_val;
    logic [5:0]  sh_nx;
    logic [4:0]  load_v;
    t_map_sel    sel;
    logic        serial_wr;
    logic [5:0]  prg_last;

    assign sel       = t_map_sel'(r_addr[14:13]);
    assign serial_wr = r_cmd && r_addr[15];
    assign sh_nx     = {r_wdata[0], r_shift[5:1]};
    assign load_v    = sh_nx[5:1];
    assign prg_last  = (r_prg_cnt == 6'd0) ? 6'd0 : (r_prg_cnt - 6'd1);

    assign o_stat.needs_mod = serial_wr && !r_wdata[7] && r_shift[1] && (sel != SEL_CONTROL);

    // restoring remainder step; a zero divisor leaves the dividend as is
    assign div_trial  = {r_div_rem, r_div_num[4]};
    assign div_rem_nx = (div_trial >= {1'b0, r_div_den}) ? 6'(div_trial - {1'b0, r_div_den})
                                                          : div_trial[5:0];
    assign bank_val   = div_rem_nx[4:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd   <= i_in_command;
            r_addr  <= i_in_address;
            r_wdata <= i_in_write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chr_cnt <= ChrCountRst;
            r_prg_cnt <= PrgCountRst;
            r_ram     <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_CHR_COUNT:   r_chr_cnt <= i_cfg_wdata[5:0];
                REG_PRG_COUNT:   r_prg_cnt <= i_cfg_wdata[5:0];
                REG_RAM_PRESENT: r_ram     <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(i_cfg_idx))
            REG_CHR_COUNT:   o_cfg_rdata = {{(CfgDataW-6){1'b0}}, r_chr_cnt};
            REG_PRG_COUNT:   o_cfg_rdata = {{(CfgDataW-6){1'b0}}, r_prg_cnt};
            REG_RAM_PRESENT: o_cfg_rdata = {{(CfgDataW-1){1'b0}}, r_ram};
            default:         o_cfg_rdata = '0;
        endcase
    end

    // translation of the held item and serial register update
    always_comb begin
        n_target   = TGT_NONE;
        n_offset   = '0;
        n_slot     = '0;
        n_shift    = r_shift;
        n_control  = r_control;
        n_chr_low  = r_chr_low;
        n_chr_high = r_chr_high;
        n_prg_low  = r_prg_low;
        if (i_cmd.exec) begin
            case (r_addr[15:13])
                RGN_CHR: begin
                    n_target = TGT_CHR;
                    n_offset = {2'b00, (r_addr[12] ? r_chr_high : r_chr_low), r_addr[11:0]};
                end
                RGN_NT: begin
                    n_target = TGT_NT;
                    n_offset = {9'd0, r_addr[9:0]};
                    n_slot   = r_addr[11:10];
                end
                RGN_IO: begin
                    n_target = TGT_NONE;
                end
                RGN_RAM: begin
                    if (r_ram) begin
                        n_target = TGT_RAM;
                        n_offset = {6'd0, r_addr[12:0]};
                    end
                end
                default: begin
                    if (r_cmd) begin
                        n_target = TGT_REG;
                        if (r_wdata[7]) begin
                            n_shift = ShiftEmpty;
                        end else if (sh_nx[0]) begin
                            n_shift = ShiftEmpty;
                            if (sel == SEL_CONTROL) begin
                                n_control = load_v;
                            end
                        end else begin
                            n_shift = sh_nx;
                        end
                    end else begin
                        n_target = TGT_ROM;
                        n_offset = {(r_addr[14] ? prg_last[4:0] : r_prg_low), r_addr[13:0]};
                    end
                end
            endcase
        end
        if (i_cmd.bank_write) begin
            case (r_div_sel)
                SEL_CHR0: begin
                    n_chr_low = bank_val;
                    if (!r_control[4]) begin
                        n_chr_high = bank_val + 5'd1;
                    end
                end
                SEL_CHR1: begin
                    if (r_control[4]) begin
                        n_chr_high = bank_val;
                    end
                end
                SEL_PRG: n_prg_low = bank_val;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift    <= ShiftEmpty;
            r_control  <= '0;
            r_chr_low  <= '0;
            r_chr_high <= ChrHighRst;
            r_prg_low  <= '0;
        end else begin
            r_shift    <= n_shift;
            r_control  <= n_control;
            r_chr_low  <= n_chr_low;
            r_chr_high <= n_chr_high;
            r_prg_low  <= n_prg_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_target  <= n_target;
            r_offset  <= n_offset;
            r_slot    <= n_slot;
            // remainder unit setup; only used when the item completes a bank load
            r_div_rem <= '0;
            r_div_sel <= sel;
            r_div_num <= (sel == SEL_CHR0 && !r_control[4]) ? {load_v[4:1], 1'b0} : load_v;
            r_div_den <= (sel == SEL_PRG) ? r_prg_cnt : r_chr_cnt;
        end else if (i_cmd.mod_step) begin
            r_div_rem <= div_rem_nx;
            r_div_num <= {r_div_num[3:0], 1'b0};
        end
    end

    assign o_target    = r_target;
    assign o_offset    = r_offset;
    assign o_slot      = r_slot;
    assign o_mirroring = r_control[1:0];

endmodule

`default_nettype wire

@@ rtl/serial_bank_switch_mapper.sv @@
// Top level of the serial bank switch mapper: controller, datapath, ports.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+-------------------------------------------
//  in_ch    | in  | valid / ready  | command, address, write_data
//  out_ch   | out | valid / ready  | target, offset, nametable_slot, mirroring
//  APB      | in  | psel / penable | paddr[3:2] register, pwdata, prdata
//
// One result per bus access. Plain accesses stream at one transfer per cycle while
// the output is ready: the held item is translated into the output register while
// the next transfer is taken in.
// A fifth serial write that loads a CHR or PRG bank holds input ready low
// through its translation and every remainder step (one dividend bit per cycle).
// A stalled output holds its result; one more item waits in the item register.
// Synchronous active-low reset: shift register empty, banks and config at reset.
`default_nettype none

module serial_bank_switch_mapper import sbsm_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    sbsm_in_if.sink                  in_ch,
    sbsm_out_if.source               out_ch,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [CfgAddrW-1:0] paddr,
    input  wire logic [CfgDataW-1:0] pwdata,
    output logic [CfgDataW-1:0]      prdata,
    output logic                     pready
);

    t_cmd    cmd;
    t_stat   stat;
    t_target target;
    logic    cfg_we;

    assign pready = 1'b1;
    // config write completes on the access phase
    assign cfg_we = psel && penable && pwrite && pready;

    sbsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sbsm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_in_command    (in_ch.command),
        .i_in_address    (in_ch.address),
        .i_in_write_data (in_ch.write_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (paddr[3:2]),
        .i_cfg_wdata     (pwdata),
        .o_cfg_rdata     (prdata),
        .o_target        (target),
        .o_offset        (out_ch.offset),
        .o_slot          (out_ch.nametable_slot),
        .o_mirroring     (out_ch.mirroring)
    );

    assign out_ch.target = target;

`ifndef SYNTHESIS
    // a new result appears only from a translation
    a_rise_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_ch.valid) |-> $past(cmd.exec))
        else $error("result valid without translation");

    // no transfer taken while a bank remainder is in progress
    a_no_accept_in_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mod_step |-> !in_ch.ready)
        else $error("input ready during bank remainder");

    // a bank load completion starts the remainder unit next cycle
    a_mod_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.exec && stat.needs_mod) |=> cmd.mod_step)
        else $error("bank load did not start remainder unit");

    // translation never runs while the result register is blocked
    a_exec_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |-> (!out_ch.valid || out_ch.ready))
        else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

@@ tb/serial_bank_switch_mapper_tb.sv @@
// Self-checking testbench for serial_bank_switch_mapper: directed table, random mix, APB setup.
`timescale 1ns / 100ps

module serial_bank_switch_mapper_tb;
    import sbsm_pkg::*;

    // Bus access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam int CYCLE_LIMIT = 600000;  // far above the slowest legal run
    localparam int SETTLE      = 12;      // covers the held item and the remainder unit, with margin
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 205;
    localparam int DIR_ROWS    = 25;

    // One translated access, laid out like the output channel payload
    typedef struct packed {
        t_target     target;
        logic [18:0] offset;
        logic [1:0]  slot;
        logic [1:0]  mirr;
    } t_xlat;

    // Directed row: access plus an optional hand-typed translation
    typedef struct packed {
        logic        cmd;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        typed;
        t_xlat       res;
    } t_row;

    localparam t_xlat NO_RES = '{TGT_NONE, 19'd0, 2'd0, 2'd0};

    logic i_clk;
    logic i_rst_n;

    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CfgAddrW-1:0] paddr;
    logic [CfgDataW-1:0] pwdata;
    logic [CfgDataW-1:0] prdata;
    logic                pready;

    sbsm_in_if  in_ch ();
    sbsm_out_if out_ch ();

    serial_bank_switch_mapper u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 20 ns period
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Mapper shadow: config plus serial/bank state, updated per transfer
    // ------------------------------------------------------------------
    logic [5:0] p_chr_cnt;
    logic [5:0] p_prg_cnt;
    logic       p_ram_on;
    logic [5:0] p_shift;
    logic [4:0] p_ctrl;
    logic [4:0] p_chr_lo;
    logic [4:0] p_chr_hi;
    logic [4:0] p_prg_lo;

    t_xlat xlat_q[$];        // translations still owed by the DUT
    int    accesses_sent;    // input transfers taken so far
    int    mismatches;
    int    cycle_cnt;

    // Idle knobs: 0 = never idle, N = start a burst about one cycle in N
    int gap_rate;
    int stall_rate;

    // Bank number reduced by the count; a zero count leaves it alone
    function automatic logic [4:0] fold_bank(logic [4:0] v, logic [5:0] cnt);
        if (cnt == 6'd0)
            return v;
        return 5'(int'(v) % int'(cnt));
    endfunction

    // Feed one write at 0x8000+ into the serial loader
    function automatic void shift_in(logic [15:0] addr, logic [7:0] data);
        logic [4:0] v;
        if (data[7]) begin
            p_shift = ShiftEmpty;     // bit 7 aborts any partial sequence
            return;
        end
        p_shift = {data[0], p_shift[5:1]};
        if (p_shift[0]) begin
            // marker reached bit 0: five data bits are complete
            v = p_shift[5:1];
            case (t_map_sel'(addr[14:13]))
                SEL_CONTROL: p_ctrl = v;
                SEL_CHR0: begin
                    if (p_ctrl[4]) begin
                        p_chr_lo = fold_bank(v, p_chr_cnt);
                    end else begin
                        // 8KB mode: low gets the even bank folded by the count, high the next one (may pass the count)
                        p_chr_lo = fold_bank(v & 5'h1E, p_chr_cnt);
                        p_chr_hi = p_chr_lo + 5'd1;
                    end
                end
                SEL_CHR1: begin
                    if (p_ctrl[4])
                        p_chr_hi = fold_bank(v, p_chr_cnt);
                end
                default: p_prg_lo = fold_bank(v, p_prg_cnt);
            endcase
            p_shift = ShiftEmpty;
        end
    endfunction

    // Translate one access and advance the shadow state
    function automatic t_xlat translate_access(logic cmd, logic [15:0] addr, logic [7:0] data);
        t_xlat      r;
        logic [4:0] cbank;
        logic [5:0] rbank;
        r = NO_RES;
        case (addr[15:13])
            RGN_CHR: begin
                cbank = addr[12] ? p_chr_hi : p_chr_lo;
                r.target = TGT_CHR;
                r.offset = {2'b00, cbank, addr[11:0]};
            end
            RGN_NT: begin
                r.target = TGT_NT;
                r.offset = {9'd0, addr[9:0]};
                r.slot   = addr[11:10];
            end
            RGN_IO: r.target = TGT_NONE;
            RGN_RAM: begin
                if (p_ram_on) begin
                    r.target = TGT_RAM;
                    r.offset = {6'd0, addr[12:0]};
                end
            end
            default: begin
                if (cmd == CMD_WRITE) begin
                    r.target = TGT_REG;
                    shift_in(addr, data);
                end else begin
                    // high window is the last bank; zero count gives bank 0
                    if (addr[14])
                        rbank = (p_prg_cnt == 6'd0) ? 6'd0 : p_prg_cnt - 6'd1;
                    else
                        rbank = {1'b0, p_prg_lo};
                    r.target = TGT_ROM;
                    r.offset = {rbank[4:0], addr[13:0]};   // 19-bit wrap drops bank bit 5
                end
            end
        endcase
        r.mirr = p_ctrl[1:0];   // mirroring as it stands after this access
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table. Hand-typed rows: reset state, window extremes,
    // bit-7 abort. Serial loads go through the shadow.
    // ------------------------------------------------------------------
    t_row dir_tab [DIR_ROWS] = '{
        // CHR low/high window at reset banks 0 and 1
        '{CMD_READ,  16'h0000, 8'h00, 1'b1, '{TGT_CHR,  19'h00000, 2'd0, 2'd0}},
        '{CMD_READ,  16'h1FFF, 8'h00, 1'b1, '{TGT_CHR,  19'h01FFF, 2'd0, 2'd0}},
        // nametable quadrant 3, write byte ignored
        '{CMD_WRITE, 16'h2C05, 8'hFF, 1'b1, '{TGT_NT,   19'h00005, 2'd3, 2'd0}},
        '{CMD_READ,  16'h3FFF, 8'h00, 1'b1, '{TGT_NT,   19'h003FF, 2'd3, 2'd0}},
        // unmapped hole
        '{CMD_READ,  16'h4000, 8'h00, 1'b1, '{TGT_NONE, 19'h00000, 2'd0, 2'd0}},
        '{CMD_WRITE, 16'h5FFF, 8'hAA, 1'b1, '{TGT_NONE, 19'h00000, 2'd0, 2'd0}},
        // PRG RAM present at reset
        '{CMD_READ,  16'h6000, 8'h00, 1'b1, '{TGT_RAM,  19'h00000, 2'd0, 2'd0}},
        '{CMD_WRITE, 16'h7FFF, 8'h55, 1'b1, '{TGT_RAM,  19'h01FFF, 2'd0, 2'd0}},
        // PRG ROM: low window bank 0, high window last of two banks
        '{CMD_READ,  16'h8000, 8'h00, 1'b1, '{TGT_ROM,  19'h00000, 2'd0, 2'd0}},
        '{CMD_READ,  16'hFFFF, 8'h00, 1'b1, '{TGT_ROM,  19'h07FFF, 2'd0, 2'd0}},
        // clear the loader
        '{CMD_WRITE, 16'h8000, 8'h80, 1'b1, '{TGT_REG,  19'h00000, 2'd0, 2'd0}},
        // control = 0x13: 4KB CHR mode, mirroring 3 (LSB first, junk in bits 6..1)
        '{CMD_WRITE, 16'h8000, 8'h7F, 1'b0, NO_RES},
        '{CMD_WRITE, 16'h9234, 8'h01, 1'b0, NO_RES},
        '{CMD_WRITE, 16'h8FFF, 8'h7E, 1'b0, NO_RES},
        '{CMD_WRITE, 16'h9FFF, 8'h00, 1'b0, NO_RES},
        '{CMD_WRITE, 16'h9ABC, 8'h41, 1'b1, '{TGT_REG,  19'h00000, 2'd0, 2'd3}},
        // two bits toward CHR bank 0, then abort
        '{CMD_WRITE, 16'hA000, 8'h01, 1'b0, NO_RES},
        '{CMD_WRITE, 16'hA001, 8'h01, 1'b0, NO_RES},
        '{CMD_WRITE, 16'hBFFF, 8'hFF, 1'b1, '{TGT_REG,  19'h00000, 2'd0, 2'd3}},
        // CHR bank 0 = 0x1F in 4KB mode, folded by count 2
        '{CMD_WRITE, 16'hA000, 8'h01, 1'b0, NO_RES},
        '{CMD_WRITE, 16'hA555, 8'h03, 1'b0, NO_RES},
        '{CMD_WRITE, 16'hBAAA, 8'h7F, 1'b0, NO_RES},
        '{CMD_WRITE, 16'hB000, 8'h11, 1'b0, NO_RES},
        '{CMD_WRITE, 16'hBFFF, 8'h21, 1'b0, NO_RES},
        '{CMD_READ,  16'h0FFF, 8'h00, 1'b0, NO_RES}
    };

    // Per-phase register settings; entries 5 and 6 are drawn at run start
    logic [5:0] ph_chr [PHASES] = '{6'd32, 6'd2, 6'd3, 6'd0, 6'd63, 6'd9, 6'd24, 6'd16};
    logic [5:0] ph_prg [PHASES] = '{6'd32, 6'd1, 6'd5, 6'd0, 6'd63, 6'd7, 6'd40, 6'd8};
    logic       ph_ram [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    int         rate_opt [3]    = '{3, 12, 0};

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One input transfer; the translation is queued at the accepting edge
    task automatic send(t_row row);
        t_xlat want;
        if (gap_rate != 0 && $urandom_range(gap_rate - 1, 0) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(15, 1)) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.command    <= row.cmd;
        in_ch.address    <= row.addr;
        in_ch.write_data <= row.data;
        do @(posedge i_clk); while (!in_ch.ready);
        want = translate_access(row.cmd, row.addr, row.data);
        if (row.typed)
            want = row.res;
        xlat_q.push_back(want);
        accesses_sent++;
    endtask

    task automatic access(logic cmd, logic [15:0] addr, logic [7:0] data);
        t_row row;
        row = '{cmd, addr, data, 1'b0, NO_RES};
        send(row);
    endtask

    // Well-formed five-write load with random filler bits, sometimes with
    // unrelated accesses in between, sometimes broken off by a bit-7 write
    task automatic serial_load();
        logic [1:0]  sel;
        logic [4:0]  v;
        logic [15:0] a;
        sel = 2'($urandom_range(3, 0));
        v   = 5'($urandom);
        for (int b = 0; b < 5; b++) begin
            if ($urandom_range(3, 0) == 0) begin
                // bystander: anything below 0x8000, or a ROM read
                a = 16'($urandom);
                if (a[15])
                    access(CMD_READ, a, 8'($urandom));
                else
                    access(1'($urandom), a, 8'($urandom));
            end
            if ($urandom_range(19, 0) == 0) begin
                access(CMD_WRITE, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
                return;
            end
            access(CMD_WRITE, {1'b1, sel, 13'($urandom)}, {1'b0, 6'($urandom), v[b]});
        end
    endtask

    task automatic run_random(int upto);
        int pick;
        while (accesses_sent < upto) begin
            pick = $urandom_range(99, 0);
            if (pick < 40)
                serial_load();
            else if (pick < 85)
                access(1'($urandom), {3'($urandom_range(7, 0)), 13'($urandom)}, 8'($urandom));
            else
                access(CMD_WRITE, {1'b1, 15'($urandom)}, 8'($urandom));   // loader noise
        end
    endtask

    // Hold the input until every owed translation has come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (xlat_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // APB write: setup cycle, access cycle, register taken when pready is high
    task automatic apb_write(t_reg_idx idx, logic [5:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= CfgDataW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CHR_COUNT:   p_chr_cnt = value;
            REG_PRG_COUNT:   p_prg_cnt = value;
            REG_RAM_PRESENT: p_ram_on  = value[0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall bursts on ready
    // ------------------------------------------------------------------
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_rate != 0 && $urandom_range(stall_rate - 1, 0) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(15, 1)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    task automatic report(string what, t_xlat want, t_xlat got);
        mismatches++;
        if (mismatches <= 10)
            $display("cycle %0d: %s: expected tgt=%0d ofs=%05h slot=%0d mir=%0d, got tgt=%0d ofs=%05h slot=%0d mir=%0d",
                     cycle_cnt, what, want.target, want.offset, want.slot, want.mirr,
                     got.target, got.offset, got.slot, got.mirr);
    endtask

    // Every output transfer is matched against the oldest owed translation
    always @(posedge i_clk) begin : chk
        t_xlat got;
        t_xlat want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.target = t_target'(out_ch.target);
            got.offset = out_ch.offset;
            got.slot   = out_ch.nametable_slot;
            got.mirr   = out_ch.mirroring;
            if (xlat_q.size() == 0) begin
                report("result with nothing owed", NO_RES, got);
            end else begin
                want = xlat_q.pop_front();
                if (got.target !== want.target || got.offset !== want.offset ||
                    got.slot !== want.slot || got.mirr !== want.mirr)
                    report("translation mismatch", want, got);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("serial_bank_switch_mapper_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        cycle_cnt     = 0;
        mismatches    = 0;
        accesses_sent = 0;
        gap_rate      = 3;
        stall_rate    = 3;

        // shadow at its reset values
        p_chr_cnt = ChrCountRst;
        p_prg_cnt = PrgCountRst;
        p_ram_on  = 1'b1;
        p_shift   = ShiftEmpty;
        p_ctrl    = 5'd0;
        p_chr_lo  = 5'd0;
        p_chr_hi  = ChrHighRst;
        p_prg_lo  = 5'd0;

        ph_chr[5] = 6'($urandom_range(32, 2));
        ph_prg[5] = 6'($urandom_range(32, 1));
        ph_ram[5] = 1'($urandom);
        ph_chr[6] = 6'($urandom_range(63, 0));   // anywhere in the field, off-range too
        ph_prg[6] = 6'($urandom_range(63, 0));
        ph_ram[6] = 1'($urandom);

        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.command    <= CMD_READ;
        in_ch.address    <= 16'd0;
        in_ch.write_data <= 8'd0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part runs on reset configuration
        for (int r = 0; r < DIR_ROWS; r++)
            send(dir_tab[r]);
        drain();

        // random phases, each with its own register setting and idle mix;
        // the last phase runs with both sides always ready
        for (int p = 0; p < PHASES; p++) begin
            apb_write(REG_CHR_COUNT, ph_chr[p]);
            apb_write(REG_PRG_COUNT, ph_prg[p]);
            apb_write(REG_RAM_PRESENT, {5'd0, ph_ram[p]});
            gap_rate   = (p == PHASES - 1) ? 0 : rate_opt[p % 3];
            stall_rate = (p == PHASES - 1) ? 0 : rate_opt[(p + 1) % 3];
            run_random(accesses_sent + PHASE_ITEMS);
            drain();
        end

        if (mismatches == 0) begin
            $display("serial_bank_switch_mapper_tb passed");
        end else begin
            $display("serial_bank_switch_mapper_tb failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/sbsm_pkg.sv
rtl/sbsm_ifs.sv
rtl/sbsm_ctrl.sv
rtl/sbsm_dp.sv
rtl/serial_bank_switch_mapper.sv
tb/serial_bank_switch_mapper_tb.sv
